/* sv/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ACLD_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define ACLD_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/acld_pkg.sv */
// Types and constants of the ASCII command line decoder.
`default_nettype none

package acld_pkg;

    // Only the first characters of a line take part in decoding.
    localparam int STORE_CHARS = 21;

    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;
    localparam logic [7:0] CHAR_DEL   = 8'h7F;

    localparam logic [23:0] KW_LED        = "LED";
    localparam logic [79:0] KW_CHENILLARD = "CHENILLARD";
    localparam logic [23:0] KW_SP_ON      = " ON";
    localparam logic [15:0] KW_ON         = "ON";
    localparam logic [23:0] KW_OFF        = "OFF";
    localparam logic [79:0] KW_SP_FREQUENCE = " FREQUENCE";
    localparam logic [47:0] KW_STATUS     = "STATUS";
    localparam logic [23:0] KW_PAT        = "PAT";
    localparam logic [31:0] KW_FREQ       = "FREQ";
    localparam logic [31:0] KW_STOP       = "STOP";

    localparam logic [2:0] KIND_STATUS = 3'd0;
    localparam logic [2:0] KIND_STOP   = 3'd1;
    localparam logic [2:0] KIND_LED    = 3'd2;
    localparam logic [2:0] KIND_PAT    = 3'd3;
    localparam logic [2:0] KIND_FREQ   = 3'd4;
    localparam logic [2:0] KIND_ERROR  = 3'd5;

    localparam logic [3:0] ERR_NONE          = 4'd0;
    localparam logic [3:0] ERR_UNKNOWN       = 4'd1;
    localparam logic [3:0] ERR_LED_SHORT     = 4'd2;
    localparam logic [3:0] ERR_LED_NUMBER    = 4'd3;
    localparam logic [3:0] ERR_LED_SPACE     = 4'd4;
    localparam logic [3:0] ERR_LED_STATE     = 4'd5;
    localparam logic [3:0] ERR_PAT_NUMBER    = 4'd6;
    localparam logic [3:0] ERR_FREQ_FORMAT   = 4'd7;
    localparam logic [3:0] ERR_FREQ_NUMBER   = 4'd8;
    localparam logic [3:0] ERR_PAT_SHORTCUT  = 4'd9;
    localparam logic [3:0] ERR_FREQ_SHORTCUT = 4'd10;
    localparam logic [3:0] ERR_BAD_SHORTCUT  = 4'd11;

    localparam logic [1:0] REG_LED_MAX = 2'd0;
    localparam logic [1:0] REG_PAT_MAX = 2'd1;

    localparam logic [3:0] NUMBER_MAX_RESET = 4'd3;

    typedef logic [STORE_CHARS-1:0][7:0] line_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] arg;
        logic       led_on;
        logic [3:0] err;
    } result_t;

endpackage

`default_nettype wire

/* sv/ascii_command_line_decoder_top.sv */
// ASCII command line decoder: line buffer, command decode and result output.
//
// Characters arrive on the input channel (in_valid, in_stall, char_in), one
// transfer per cycle. Lower case is folded to upper case, line feed is
// dropped, backspace and DEL erase the last character, printable characters
// are stored until the line holds LINE_DEPTH-1 of them. A carriage return on
// a non-empty line yields one result on the output channel (out_valid,
// out_stall, command_kind, argument, led_on, error_code), in the cycle after
// its transfer unless the output is stalled; an empty line yields none.
// Every carriage return clears the line. Throughput is one character per
// cycle while in_stall is low; decode compares fixed positions in parallel.
// When the receiver stalls, the output register holds its result and a skid
// register takes one more; in_stall rises only while the skid register is
// full and drops in the cycle after the output drains.
// Reset clears the line, empties both result registers and sets both number
// limits (cfg_index 0 LED, 1 pattern) to 3. Write limits only while idle.
`default_nettype none

module ascii_command_line_decoder_top import acld_pkg::*;
#(
    parameter int LINE_DEPTH = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] command_kind,
    output logic [3:0] argument,
    output logic       led_on,
    output logic [3:0] error_code
);

    localparam int LEN_W = $clog2(LINE_DEPTH);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_DEPTH - 1);

    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    line_t            line_reg;
    logic [3:0]       led_max_reg;
    logic [3:0]       pat_max_reg;
    logic             out_valid_reg;
    result_t          out_data_reg;
    logic             skid_valid_reg;
    result_t          skid_data_reg;

    logic       in_fire;
    logic       out_fire;
    logic [7:0] char_up;
    logic       is_print;
    logic       is_erase;
    logic       wr_en;
    logic       res_valid;
    result_t    res_data;

    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;
    assign char_up  = (char_in >= "a" && char_in <= "z") ? char_in - 8'd32 : char_in;
    assign is_print = (char_up >= CHAR_SPACE) && (char_up <= CHAR_TILDE);
    assign is_erase = (char_up == CHAR_BS) || (char_up == CHAR_DEL);

    always_comb
    begin
        len_next  = len_reg;
        wr_en     = 1'b0;
        res_valid = 1'b0;
        if (in_fire)
        begin
            if (char_up == CHAR_CR)
            begin
                len_next  = '0;
                res_valid = (len_reg != '0);
            end
            else if (is_erase)
            begin
                if (len_reg != '0)
                    len_next = len_reg - LEN_W'(1);
            end
            else if (is_print && len_reg < LEN_LIMIT)
            begin
                wr_en    = 1'b1;
                len_next = len_reg + LEN_W'(1);
            end
        end
    end

    acld_decode #(
        .LEN_W (LEN_W)
    ) u_decode (
        .line    (line_reg),
        .len     (len_reg),
        .led_max (led_max_reg),
        .pat_max (pat_max_reg),
        .result  (res_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= '0;
            led_max_reg <= NUMBER_MAX_RESET;
            pat_max_reg <= NUMBER_MAX_RESET;
        end
        else
        begin
            len_reg <= len_next;
            if (cfg_write && cfg_index == REG_LED_MAX)
                led_max_reg <= cfg_data;
            if (cfg_write && cfg_index == REG_PAT_MAX)
                pat_max_reg <= cfg_data;
        end
    end

    // Characters past the decoded window are counted but not kept.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STORE_CHARS; i++)
        begin
            if (wr_en && len_reg == LEN_W'(i))
                line_reg[i] <= char_up;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // Input is held off; drain the skid register on an output transfer.
            if (out_fire)
                skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_fire)
            out_valid_reg <= res_valid;
        else if (res_valid)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
                out_data_reg <= skid_data_reg;
        end
        else if (!out_valid_reg || out_fire)
            out_data_reg <= res_data;
        else if (res_valid)
            skid_data_reg <= res_data;
    end

    assign in_stall     = skid_valid_reg;
    assign out_valid    = out_valid_reg;
    assign command_kind = out_data_reg.kind;
    assign argument     = out_data_reg.arg;
    assign led_on       = out_data_reg.led_on;
    assign error_code   = out_data_reg.err;

endmodule

`default_nettype wire

/* sv/acld_decode.sv */
// Decoder from a stored line to one command result.
`default_nettype none

module acld_decode import acld_pkg::*;
#(
    parameter int LEN_W = 6
)
(
    input  line_t            line,
    input  logic [LEN_W-1:0] len,
    input  logic [3:0]       led_max,
    input  logic [3:0]       pat_max,
    output result_t          result
);

    logic led_num_ok;
    logic pat_num_ok;
    logic chen_num_ok;
    logic digit10;
    logic freq20_ok;
    logic freq4_ok;

    function automatic logic number_ok(input logic [7:0] c, input logic [3:0] max);
        logic [8:0] hi;
        hi = 9'h030 + {5'b0, max};
        return ({1'b0, c} >= 9'h031) && ({1'b0, c} <= hi);
    endfunction

    function automatic logic freq_ok(input logic [7:0] c);
        return (c >= "1") && (c <= "3");
    endfunction

    assign led_num_ok  = number_ok(line[3], led_max);
    assign pat_num_ok  = number_ok(line[3], pat_max);
    assign chen_num_ok = number_ok(line[10], pat_max);
    assign digit10     = (line[10] >= "0") && (line[10] <= "9");
    assign freq20_ok   = freq_ok(line[20]);
    assign freq4_ok    = freq_ok(line[4]);

    always_comb
    begin
        result      = '0;
        result.kind = KIND_ERROR;
        result.err  = ERR_UNKNOWN;
        if (len == LEN_W'(6) && {line[0], line[1], line[2], line[3], line[4], line[5]}
                == KW_STATUS)
        begin
            result.kind = KIND_STATUS;
            result.err  = ERR_NONE;
        end
        else if (len == LEN_W'(4) && {line[0], line[1], line[2], line[3]} == KW_STOP)
        begin
            result.kind = KIND_STOP;
            result.err  = ERR_NONE;
        end
        else if (len >= LEN_W'(3) && {line[0], line[1], line[2]} == KW_LED)
        begin
            if (len < LEN_W'(7))
                result.err = ERR_LED_SHORT;
            else if (!led_num_ok)
                result.err = ERR_LED_NUMBER;
            else if (line[4] != CHAR_SPACE)
                result.err = ERR_LED_SPACE;
            else if (len == LEN_W'(7) && {line[5], line[6]} == KW_ON)
            begin
                result.kind   = KIND_LED;
                result.arg    = line[3][3:0];
                result.led_on = 1'b1;
                result.err    = ERR_NONE;
            end
            else if (len == LEN_W'(8) && {line[5], line[6], line[7]} == KW_OFF)
            begin
                result.kind = KIND_LED;
                result.arg  = line[3][3:0];
                result.err  = ERR_NONE;
            end
            else
                result.err = ERR_LED_STATE;
        end
        else if (len >= LEN_W'(10) && {line[0], line[1], line[2], line[3], line[4],
                 line[5], line[6], line[7], line[8], line[9]} == KW_CHENILLARD)
        begin
            if (len == LEN_W'(14) && digit10 && {line[11], line[12], line[13]} == KW_SP_ON)
            begin
                if (!chen_num_ok)
                    result.err = ERR_PAT_NUMBER;
                else
                begin
                    result.kind = KIND_PAT;
                    result.arg  = line[10][3:0];
                    result.err  = ERR_NONE;
                end
            end
            else if (len >= LEN_W'(20) && {line[10], line[11], line[12], line[13], line[14],
                     line[15], line[16], line[17], line[18], line[19]} == KW_SP_FREQUENCE)
            begin
                if (len != LEN_W'(21))
                    result.err = ERR_FREQ_FORMAT;
                else if (!freq20_ok)
                    result.err = ERR_FREQ_NUMBER;
                else
                begin
                    result.kind = KIND_FREQ;
                    result.arg  = line[20][3:0] - 4'd1;
                    result.err  = ERR_NONE;
                end
            end
            else
                result.err = ERR_UNKNOWN;
        end
        else if (len == LEN_W'(4) && {line[0], line[1], line[2]} == KW_PAT)
        begin
            if (!pat_num_ok)
                result.err = ERR_PAT_SHORTCUT;
            else
            begin
                result.kind = KIND_PAT;
                result.arg  = line[3][3:0];
                result.err  = ERR_NONE;
            end
        end
        else if (len == LEN_W'(5) && {line[0], line[1], line[2], line[3]} == KW_FREQ)
        begin
            if (!freq4_ok)
                result.err = ERR_FREQ_SHORTCUT;
            else
            begin
                result.kind = KIND_FREQ;
                result.arg  = line[4][3:0] - 4'd1;
                result.err  = ERR_NONE;
            end
        end
        else if ((len >= LEN_W'(3) && {line[0], line[1], line[2]} == KW_PAT) ||
                 (len >= LEN_W'(4) && {line[0], line[1], line[2], line[3]} == KW_FREQ))
            result.err = ERR_BAD_SHORTCUT;
    end

endmodule

`default_nettype wire

/* sv/acld_checker.sv */
// Port-level checker for the ASCII command line decoder, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module acld_checker import acld_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] char_in,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] command_kind,
    input logic [3:0] argument,
    input logic       led_on,
    input logic [3:0] error_code
);

    `ACLD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

    `ACLD_ASSERT(a_stall_hold,
        out_valid && out_stall |=> out_valid && $stable(command_kind) && $stable(argument)
            && $stable(led_on) && $stable(error_code),
        "stalled result changed")

    `ACLD_ASSERT(a_result_after_cr,
        $rose(out_valid) |-> $past(in_valid && !in_stall && char_in == CHAR_CR),
        "result without a carriage return transfer")

    `ACLD_ASSERT(a_error_fields,
        out_valid && command_kind == KIND_ERROR |->
            error_code != ERR_NONE && argument == 4'd0 && !led_on,
        "error result with stray fields")

    `ACLD_ASSERT(a_ok_fields,
        out_valid && command_kind != KIND_ERROR |->
            error_code == ERR_NONE && (!led_on || command_kind == KIND_LED),
        "command result with stray fields")

endmodule

bind ascii_command_line_decoder_top acld_checker u_acld_checker (.*);

`default_nettype wire

/* tb/sv/acld_tb_pkg.sv */
// Scoreboard for the ASCII command line decoder: line buffer, decode and result checks.
package acld_tb_pkg;
    import acld_pkg::*;

    localparam int LINE_DEPTH = 64;

    // Indexes past the two limits; writes to them must change nothing.
    localparam logic [1:0] REG_SPARE_A = 2'd2;
    localparam logic [1:0] REG_SPARE_B = 2'd3;

    class command_scoreboard;
        bit [7:0]   line_buf [LINE_DEPTH];
        int         line_len;
        logic [3:0] led_max;
        logic [3:0] pat_max;
        result_t    expected_commands [$];
        int         failures;
        int         commands_checked;
        int         lines_ended;
        int         kind_seen [6];

        function new();
            clear_line();
            led_max = NUMBER_MAX_RESET;
            pat_max = NUMBER_MAX_RESET;
        endfunction

        function void clear_line();
            foreach (line_buf[i])
                line_buf[i] = 8'h00;
            line_len = 0;
        endfunction

        function void set_limit(logic [1:0] idx, logic [3:0] val);
            case (idx)
                REG_LED_MAX: led_max = val;
                REG_PAT_MAX: pat_max = val;
                default: ;
            endcase
        endfunction

        function bit has_at(int pos, string s);
            for (int i = 0; i < s.len(); i++)
            begin
                if (pos + i >= line_len)
                    return 1'b0;
                if (line_buf[pos + i] != s[i])
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function bit is_exact(int pos, string s);
            return has_at(pos, s) && (pos + s.len() == line_len);
        endfunction

        function bit [7:0] char_at(int pos);
            return (pos < line_len) ? line_buf[pos] : 8'h00;
        endfunction

        // A register above 9 also lets the characters after '9' through.
        function bit number_ok(bit [7:0] c, logic [3:0] max);
            int unsigned top;
            top = 32'("0") + 32'(max);
            return (c >= "1") && (32'(c) <= top);
        endfunction

        function result_t command_result(logic [2:0] kind, logic [3:0] arg, logic on);
            result_t r;
            r.kind   = kind;
            r.arg    = arg;
            r.led_on = on;
            r.err    = ERR_NONE;
            return r;
        endfunction

        function result_t error_result(logic [3:0] code);
            result_t r;
            r.kind   = KIND_ERROR;
            r.arg    = 4'd0;
            r.led_on = 1'b0;
            r.err    = code;
            return r;
        endfunction

        function result_t decode_line();
            bit [7:0] c;
            if (is_exact(0, "STATUS"))
                return command_result(KIND_STATUS, 4'd0, 1'b0);
            if (is_exact(0, "STOP"))
                return command_result(KIND_STOP, 4'd0, 1'b0);
            if (has_at(0, "LED"))
            begin
                if (line_len < 7)
                    return error_result(ERR_LED_SHORT);
                c = char_at(3);
                if (!number_ok(c, led_max))
                    return error_result(ERR_LED_NUMBER);
                if (char_at(4) != CHAR_SPACE)
                    return error_result(ERR_LED_SPACE);
                if (is_exact(5, "ON"))
                    return command_result(KIND_LED, 4'(c - "0"), 1'b1);
                if (is_exact(5, "OFF"))
                    return command_result(KIND_LED, 4'(c - "0"), 1'b0);
                return error_result(ERR_LED_STATE);
            end
            if (has_at(0, "CHENILLARD"))
            begin
                c = char_at(10);
                if (line_len >= 14 && c >= "0" && c <= "9" && is_exact(11, " ON"))
                begin
                    if (!number_ok(c, pat_max))
                        return error_result(ERR_PAT_NUMBER);
                    return command_result(KIND_PAT, 4'(c - "0"), 1'b0);
                end
                if (has_at(10, " FREQUENCE"))
                begin
                    if (line_len != 21)
                        return error_result(ERR_FREQ_FORMAT);
                    c = char_at(20);
                    if (c < "1" || c > "3")
                        return error_result(ERR_FREQ_NUMBER);
                    return command_result(KIND_FREQ, 4'(c - "1"), 1'b0);
                end
                return error_result(ERR_UNKNOWN);
            end
            if (has_at(0, "PAT") && line_len == 4)
            begin
                c = char_at(3);
                if (!number_ok(c, pat_max))
                    return error_result(ERR_PAT_SHORTCUT);
                return command_result(KIND_PAT, 4'(c - "0"), 1'b0);
            end
            if (has_at(0, "FREQ") && line_len == 5)
            begin
                c = char_at(4);
                if (c < "1" || c > "3")
                    return error_result(ERR_FREQ_SHORTCUT);
                return command_result(KIND_FREQ, 4'(c - "1"), 1'b0);
            end
            if (has_at(0, "PAT") || has_at(0, "FREQ"))
                return error_result(ERR_BAD_SHORTCUT);
            return error_result(ERR_UNKNOWN);
        endfunction

        // Update the line for one accepted character; a carriage return queues its command.
        function void take_char(bit [7:0] raw);
            bit [7:0] c;
            c = raw;
            if (c >= "a" && c <= "z")
                c = c - ("a" - "A");
            if (c == CHAR_LF)
                return;
            if (c == CHAR_CR)
            begin
                lines_ended++;
                if (line_len != 0)
                    expected_commands.push_back(decode_line());
                clear_line();
                return;
            end
            if (c == CHAR_BS || c == CHAR_DEL)
            begin
                if (line_len > 0)
                begin
                    line_len--;
                    line_buf[line_len] = 8'h00;
                end
                return;
            end
            // Drop printable characters once the line is full.
            if (c >= CHAR_SPACE && c <= CHAR_TILDE && line_len < LINE_DEPTH - 1)
            begin
                line_buf[line_len] = c;
                line_len++;
            end
        endfunction

        function void flag(string what, result_t want, result_t got);
            failures++;
            if (failures <= 10)
                $display("%s: expected kind %0d arg %0d on %0b err %0d, got kind %0d arg %0d on %0b err %0d",
                         what, want.kind, want.arg, want.led_on, want.err,
                         got.kind, got.arg, got.led_on, got.err);
        endfunction

        function void compare_command(result_t got);
            result_t want;
            if (expected_commands.size() == 0)
            begin
                flag("unexpected result", '0, got);
                return;
            end
            want = expected_commands.pop_front();
            commands_checked++;
            kind_seen[want.kind]++;
            if (got.kind !== want.kind || got.arg !== want.arg
                || got.led_on !== want.led_on || got.err !== want.err)
                flag("result mismatch", want, got);
        endfunction
    endclass

endpackage

/* tb/sv/tb_ascii_command_line_decoder_top.sv */
// Testbench for ascii_command_line_decoder_top: directed and random command lines.
module tb_ascii_command_line_decoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    import acld_pkg::*;
    import acld_tb_pkg::*;

    typedef bit [7:0] char_q_t [$];

    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASE_ITEMS  = 100;
    localparam int HOLD_CYCLES  = 150;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASES       = 6;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_write = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [3:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    logic [7:0] char_in = '0;
    logic       out_stall = 1'b0;
    wire        in_stall;
    wire        out_valid;
    wire  [2:0] command_kind;
    wire  [3:0] argument;
    wire        led_on;
    wire  [3:0] error_code;

    command_scoreboard sb = new();

    bit calm;
    bit hold_request;
    int holds_done;
    int effective_items;
    int chars_sent;
    int cycle_count;

    ascii_command_line_decoder_top #(.LINE_DEPTH(LINE_DEPTH)) uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .char_in(char_in),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .command_kind(command_kind),
        .argument(argument),
        .led_on(led_on),
        .error_code(error_code)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    function automatic bit [7:0] printable();
        return 8'($urandom_range(CHAR_SPACE, CHAR_TILDE));
    endfunction

    // Control bytes other than CR and BS, or bytes with the top bit set.
    function automatic bit [7:0] ignored_byte();
        bit [7:0] b;
        if ($urandom_range(0, 1))
            return 8'($urandom_range(8'h80, 8'hFF));
        b = 8'($urandom_range(0, 31));
        if (b == CHAR_CR || b == CHAR_BS)
            b = CHAR_LF;
        return b;
    endfunction

    function automatic bit [7:0] pick_digit();
        if ($urandom_range(0, 9) < 8)
            return 8'($urandom_range("0", "?"));
        return printable();
    endfunction

    function automatic void put_text(ref char_q_t q, input string s);
        bit [7:0] ch;
        for (int i = 0; i < s.len(); i++)
        begin
            if ($urandom_range(0, 99) < 4)
            begin
                q.push_back(printable());
                q.push_back($urandom_range(0, 1) ? CHAR_BS : CHAR_DEL);
            end
            if ($urandom_range(0, 99) < 3)
                q.push_back(ignored_byte());
            ch = s[i];
            if (ch >= "A" && ch <= "Z" && $urandom_range(0, 9) < 3)
                ch = ch + ("a" - "A");
            q.push_back(ch);
        end
    endfunction

    function automatic void mutate(ref char_q_t q);
        int n;
        case ($urandom_range(0, 3))
            0:
            begin
                n = (q.size() > 0) ? $urandom_range(0, q.size() - 1) : 0;
                while (q.size() > n)
                    void'(q.pop_back());
            end
            1:
                repeat ($urandom_range(1, 3)) q.push_back(printable());
            2:
                if (q.size() > 0)
                    q[$urandom_range(0, q.size() - 1)] = printable();
            default:
                q.insert($urandom_range(0, q.size()), CHAR_SPACE);
        endcase
    endfunction

    // Mostly well-formed commands with random case, digits and edits; some noise.
    function automatic char_q_t random_line();
        char_q_t q;
        int shape;
        shape = $urandom_range(0, 99);
        if (shape < 4)
        begin
        end
        else if (shape < 12)
        begin
            repeat ($urandom_range(1, 12))
                q.push_back($urandom_range(0, 1) ? ignored_byte() : 8'($urandom_range(0, 255)));
            foreach (q[i])
                if (q[i] == CHAR_CR)
                    q[i] = CHAR_LF;
        end
        else if (shape < 15)
        begin
            if ($urandom_range(0, 1))
                put_text(q, "STOP");
            repeat ($urandom_range(55, 75)) q.push_back(printable());
        end
        else
        begin
            if ($urandom_range(0, 99) < 5)
                q.push_back(CHAR_BS);
            case ($urandom_range(0, 6))
                0: put_text(q, "STATUS");
                1: put_text(q, "STOP");
                2:
                begin
                    put_text(q, "LED");
                    q.push_back(pick_digit());
                    if ($urandom_range(0, 1))
                        put_text(q, " ON");
                    else
                        put_text(q, " OFF");
                end
                3:
                begin
                    put_text(q, "CHENILLARD");
                    q.push_back(pick_digit());
                    put_text(q, " ON");
                end
                4:
                begin
                    put_text(q, "CHENILLARD FREQUENCE");
                    q.push_back(pick_digit());
                end
                5:
                begin
                    put_text(q, "PAT");
                    q.push_back(pick_digit());
                end
                default:
                begin
                    put_text(q, "FREQ");
                    q.push_back(pick_digit());
                end
            endcase
            if ($urandom_range(0, 99) < 25)
                mutate(q);
        end
        q.push_back(CHAR_CR);
        if ($urandom_range(0, 3) == 0)
            q.push_back(CHAR_LF);
        return q;
    endfunction

    function automatic bit counts_as_item(bit [7:0] c);
        return c == CHAR_CR || c == CHAR_BS || c == CHAR_DEL
               || (c >= CHAR_SPACE && c <= CHAR_TILDE);
    endfunction

    // Offer one character and hold it until the transfer happens.
    task automatic send_char(input bit [7:0] c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        char_in <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.take_char(c);
        chars_sent++;
        if (counts_as_item(c))
            effective_items++;
    endtask

    task automatic send_line(input char_q_t q);
        foreach (q[i])
            send_char(q[i]);
    endtask

    task automatic send_text(input string s, input bit end_line = 1'b1);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
        if (end_line)
            send_char(CHAR_CR);
    endtask

    // Drop valid, then wait for every queued command plus the decode latency.
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (sb.expected_commands.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_limits(input logic [3:0] led_max, input logic [3:0] pat_max,
                                input logic [1:0] spare);
        cfg_write <= 1'b1;
        cfg_index <= REG_LED_MAX;
        cfg_data <= led_max;
        @(posedge clk);
        cfg_index <= REG_PAT_MAX;
        cfg_data <= pat_max;
        @(posedge clk);
        cfg_index <= spare;
        cfg_data <= 4'($urandom_range(0, 15));
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_limit(REG_LED_MAX, led_max);
        sb.set_limit(REG_PAT_MAX, pat_max);
    endtask

    always @(posedge clk)
    begin : result_monitor
        result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.kind   = command_kind;
            got.arg    = argument;
            got.led_on = led_on;
            got.err    = error_code;
            sb.compare_command(got);
        end
    end

    initial
    begin : receiver
        int n;
        forever
        begin
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                holds_done++;
            end
            n = pick_gap();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("ascii_command_line_decoder_top verification failed");
        $finish;
    end

    initial
    begin : stimulus
        int stop_at;
        int line_no;
        int failures;
        logic [3:0] led_sel;
        logic [3:0] pat_sel;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines at the reset limits.
        send_char(CHAR_CR);
        send_text("status");
        send_text("STOP");
        send_text("LED1 ON");
        send_text("led3 off");
        send_text("LED4 ON");
        send_text("LED");
        send_text("LED1XON");
        send_text("LED2 UP");
        send_text("CHENILLARD2 ON");
        send_text("CHENILLARD0 ON");
        send_text("CHENILLARD FREQUENCE2");
        send_text("CHENILLARD FREQUENCE22");
        send_text("CHENILLARD FREQUENCE4");
        send_text("CHENILLARD7");
        send_text("PAT1");
        send_text("PAT0");
        send_text("FREQ3");
        send_text("FREQ0");
        send_text("PATTERN");
        send_text("HELLO");
        // erase on an empty line, then a DEL correction
        send_char(CHAR_BS);
        send_text("STOX", 1'b0);
        send_char(CHAR_DEL);
        send_text("P");
        send_text("ST", 1'b0);
        send_char(8'h00);
        send_char(8'h80);
        send_char(8'hFF);
        send_char(CHAR_LF);
        send_text("ATUS");
        // overfill the line so the tail is dropped
        repeat (70) send_char("Q");
        send_char(CHAR_BS);
        send_char(CHAR_CR);

        // Hold the output long enough that the block backs up into its input.
        calm = 1'b1;
        hold_request = 1'b1;
        repeat (20) send_text("STOP");
        calm = 1'b0;

        line_no = 0;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                wait_quiet();
                case (phase)
                    1: begin led_sel = 4'd0;  pat_sel = 4'd0;  end
                    2: begin led_sel = 4'd15; pat_sel = 4'd15; end
                    3: begin led_sel = 4'd1;  pat_sel = 4'd9;  end
                    4: begin led_sel = 4'd9;  pat_sel = 4'd1;  end
                    default:
                    begin
                        led_sel = 4'($urandom_range(0, 15));
                        pat_sel = 4'($urandom_range(0, 15));
                    end
                endcase
                apply_limits(led_sel, pat_sel, phase[0] ? REG_SPARE_A : REG_SPARE_B);
            end
            stop_at = effective_items + PHASE_ITEMS;
            while (effective_items < stop_at)
            begin
                if (line_no % 8 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                send_line(random_line());
                line_no++;
            end
        end
        calm = 1'b0;
        wait_quiet();

        failures = sb.failures + sb.expected_commands.size();
        $display("Sent %0d characters in %0d lines across %0d limit settings, %0d long holds.",
                 chars_sent, sb.lines_ended, PHASES, holds_done);
        $display("Checked %0d commands: status %0d stop %0d led %0d pattern %0d",
                 sb.commands_checked, sb.kind_seen[KIND_STATUS], sb.kind_seen[KIND_STOP],
                 sb.kind_seen[KIND_LED], sb.kind_seen[KIND_PAT]);
        $display("  freq %0d error %0d.", sb.kind_seen[KIND_FREQ], sb.kind_seen[KIND_ERROR]);
        if (failures == 0)
            $display("ascii_command_line_decoder_top verification clean");
        else
            $display("ascii_command_line_decoder_top verification failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/acld_pkg.sv
sv/acld_decode.sv
sv/ascii_command_line_decoder_top.sv
sv/acld_checker.sv
tb/sv/acld_tb_pkg.sv
tb/sv/tb_ascii_command_line_decoder_top.sv
